FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock edge, ignored while reset is active.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Assert that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hw/rtl/zx0sd_pkg.sv
// Package with the types and constants of the ZX0 stream decompressor.
package zx0sd_pkg;
	localparam int WindowDepthDef = 32768;
	localparam int LengthBitsDef  = 16;
	localparam int InitialOffset  = 1;
	localparam int EndMark        = 256;
	localparam int OffW           = 17;
	localparam int OffGammaCap    = 65535;

	localparam logic       ACT_BYTE = 1'b0;
	localparam logic       ACT_TICK = 1'b1;
	localparam logic [1:0] ST_NEED  = 2'd0;
	localparam logic [1:0] ST_COPY  = 2'd1;
	localparam logic [1:0] ST_END   = 2'd2;
	localparam logic [1:0] ST_ERROR = 2'd3;

	typedef enum logic [3:0] {
		PH_LIT_GAMMA, PH_LIT_BYTES, PH_SEL_LIT, PH_REP_GAMMA, PH_COPY,
		PH_SEL_COPY, PH_OFF_GAMMA, PH_OFF_BYTE, PH_LEN_GAMMA, PH_END, PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE, S_BITS, S_RD, S_WR, S_OUT
	} seq_t;
endpackage

FILE: hw/rtl/zx0sd_in_if.sv
// Input channel: compressed bytes and drain ticks.
interface zx0sd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_byte;
	modport source (output valid, output action, output in_byte, input ready);
	modport sink (input valid, input action, input in_byte, output ready);
endinterface

FILE: hw/rtl/zx0sd_out_if.sv
// Output channel: one result item per input item.
interface zx0sd_out_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [1:0] status;
	modport source (output valid, output out_valid, output out_byte, output status,
		input ready);
	modport sink (input valid, input out_valid, input out_byte, input status,
		output ready);
endinterface

FILE: hw/rtl/zx0_stream_decompressor.sv
// ZX0 stream decompressor. Each input item (a compressed byte or a drain tick) gives exactly
// one result item. A literal byte inside a run, an ignored byte and an idle tick go from the
// accept state straight to the result state. A compressed byte that feeds the gamma parser,
// the last literal of a run and a new offset byte pass through the bit state first, where they
// release their code bits (up to eight); one bit-serial gamma unit consumes a single bit per
// cycle. A drain tick during a copy passes through a read state and a write state, set by the
// registered read of the history memory; the tick that ends the copy then goes on to the bit
// state for the buffered code bits that follow. The input is not ready while an item is in work
// or its result waits to be taken. The history memory holds WINDOW_DEPTH bytes and needs no
// clearing after reset; it is only read where it was written.
module zx0_stream_decompressor
	import zx0sd_pkg::*;
#(
	parameter int WINDOW_DEPTH = zx0sd_pkg::WindowDepthDef,
	parameter int LENGTH_BITS  = zx0sd_pkg::LengthBitsDef
) (
	input logic clk,
	input logic arst_n,
	zx0sd_in_if.sink    in_ch,
	zx0sd_out_if.source out_ch
);
	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int PCW = $clog2(WINDOW_DEPTH + 1);
	localparam int GW  = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam int RW  = LENGTH_BITS + 1;
	localparam logic [GW:0]     LenCap = (GW+1)'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [GW:0]     OffCap = (GW+1)'(OffGammaCap);
	localparam logic [AW-1:0]   WpLast = AW'(WINDOW_DEPTH - 1);
	localparam logic [OffW:0]   WinX   = (OffW+1)'(WINDOW_DEPTH);
	localparam logic [OffW-1:0] WinOff = OffW'(WINDOW_DEPTH);
	localparam logic [OffW-1:0] WinBad = OffW'(WINDOW_DEPTH + 1);

	seq_t            seq_q, seq_nx;
	phase_t          phase_q;
	logic [8:0]      mask_q;
	logic [7:0]      buf_q;
	logic            reuse_q;
	logic [7:0]      last_raw_q;
	logic [GW-1:0]   gamma_q;
	logic            half_q;
	logic [OffW-1:0] ro_q;
	logic [RW-1:0]   rem_q;
	logic [AW-1:0]   wp_q;
	logic [PCW-1:0]  prod_q;
	logic            res_vld_q;
	logic [7:0]      res_byte_q;

	logic            accept;
	logic            is_bit, have_bit, bit_ok, cur_bit, inv, gdone;
	logic [GW:0]     shifted, cap, capped;
	logic [RW-1:0]   rem_dec;
	logic            rem_zero;
	logic [OffW:0]   idx_x;
	logic [23:0]     off_x;
	logic            bad_off;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [7:0]      wdata, rdata;

	assign accept = in_ch.valid && in_ch.ready;

	// Bit source and one gamma step, shared by all code phases.
	always_comb begin
		is_bit = (phase_q == PH_LIT_GAMMA) || (phase_q == PH_SEL_LIT) ||
			(phase_q == PH_REP_GAMMA) || (phase_q == PH_SEL_COPY) ||
			(phase_q == PH_OFF_GAMMA) || (phase_q == PH_LEN_GAMMA);
		have_bit = reuse_q || (mask_q > 9'd1);
		bit_ok   = is_bit && have_bit;
		cur_bit  = reuse_q ? last_raw_q[0] : |(buf_q & mask_q[8:1]);
		inv      = (phase_q == PH_OFF_GAMMA);
		cap      = inv ? OffCap : LenCap;
		shifted  = {gamma_q, cur_bit ^ inv};
		capped   = (shifted > cap) ? cap : shifted;
		gdone    = !half_q && cur_bit;
		rem_dec  = (rem_q != '0) ? rem_q - RW'(1) : rem_q;
		rem_zero = (rem_dec == '0);
		bad_off  = (ro_q > OffW'(prod_q)) || (ro_q > WinOff);
		off_x    = {ro_q, 7'b0} - 24'(in_ch.in_byte[7:1]);
		idx_x    = ((OffW+1)'(wp_q) >= (OffW+1)'(ro_q)) ?
			(OffW+1)'(wp_q) - (OffW+1)'(ro_q) :
			(OffW+1)'(wp_q) + WinX - (OffW+1)'(ro_q);
	end

	// Sequencer next state.
	always_comb begin
		seq_nx = seq_q;
		case (seq_q)
			S_IDLE: begin
				if (accept) begin
					if (in_ch.action == ACT_BYTE) begin
						if (phase_q == PH_LIT_BYTES) begin
							seq_nx = rem_zero ? S_BITS : S_OUT;
						end else if (phase_q == PH_OFF_BYTE || is_bit) begin
							seq_nx = S_BITS;
						end else begin
							seq_nx = S_OUT;
						end
					end else begin
						seq_nx = (phase_q == PH_COPY) ? S_RD : S_OUT;
					end
				end
			end
			S_BITS: begin
				if (!bit_ok) begin
					seq_nx = S_OUT;
				end
			end
			S_RD: seq_nx = S_WR;
			S_WR: seq_nx = rem_zero ? S_BITS : S_OUT;
			S_OUT: begin
				if (out_ch.ready) begin
					seq_nx = S_IDLE;
				end
			end
			default: seq_nx = S_IDLE;
		endcase
	end

	// Sequencer outputs and history memory port control.
	always_comb begin
		in_ch.ready  = (seq_q == S_IDLE);
		out_ch.valid = (seq_q == S_OUT);
		we    = 1'b0;
		waddr = wp_q;
		wdata = rdata;
		raddr = idx_x[AW-1:0];
		if (seq_q == S_IDLE && accept && in_ch.action == ACT_BYTE &&
			phase_q == PH_LIT_BYTES) begin
			we    = 1'b1;
			wdata = in_ch.in_byte;
		end else if (seq_q == S_WR) begin
			we = 1'b1;
		end
	end

	always_comb begin
		out_ch.out_valid = res_vld_q;
		out_ch.out_byte  = res_byte_q;
		case (phase_q)
			PH_COPY:  out_ch.status = ST_COPY;
			PH_END:   out_ch.status = ST_END;
			PH_ERROR: out_ch.status = ST_ERROR;
			default:  out_ch.status = ST_NEED;
		endcase
	end

	// Datapath and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= S_IDLE;
			phase_q    <= PH_LIT_GAMMA;
			mask_q     <= '0;
			buf_q      <= '0;
			reuse_q    <= 1'b0;
			last_raw_q <= '0;
			gamma_q    <= GW'(1);
			half_q     <= 1'b0;
			ro_q       <= OffW'(InitialOffset);
			rem_q      <= '0;
			wp_q       <= '0;
			prod_q     <= '0;
			res_vld_q  <= 1'b0;
			res_byte_q <= '0;
		end else begin
			seq_q <= seq_nx;
			case (seq_q)
				S_IDLE: begin
					if (accept) begin
						res_vld_q  <= 1'b0;
						res_byte_q <= '0;
						if (in_ch.action == ACT_BYTE) begin
							if (phase_q == PH_LIT_BYTES) begin
								res_vld_q  <= 1'b1;
								res_byte_q <= in_ch.in_byte;
								wp_q   <= (wp_q == WpLast) ? '0 : wp_q + AW'(1);
								prod_q <= (prod_q < PCW'(WINDOW_DEPTH)) ?
									prod_q + PCW'(1) : prod_q;
								rem_q <= rem_dec;
								if (rem_zero) begin
									phase_q <= PH_SEL_LIT;
								end
							end else if (phase_q == PH_OFF_BYTE) begin
								ro_q <= (off_x > 24'(WINDOW_DEPTH)) ? WinBad :
									off_x[OffW-1:0];
								last_raw_q <= in_ch.in_byte;
								reuse_q    <= 1'b1;
								phase_q    <= PH_LEN_GAMMA;
							end else if (is_bit) begin
								buf_q  <= in_ch.in_byte;
								mask_q <= 9'h100;
							end
						end
					end
				end
				S_BITS: begin
					if (bit_ok) begin
						if (reuse_q) begin
							reuse_q <= 1'b0;
						end else begin
							mask_q <= mask_q >> 1;
						end
						if (phase_q == PH_SEL_LIT) begin
							phase_q <= cur_bit ? PH_OFF_GAMMA : PH_REP_GAMMA;
						end else if (phase_q == PH_SEL_COPY) begin
							phase_q <= cur_bit ? PH_OFF_GAMMA : PH_LIT_GAMMA;
						end else if (gdone) begin
							gamma_q <= GW'(1);
							case (phase_q)
								PH_LIT_GAMMA: begin
									rem_q   <= RW'(gamma_q);
									phase_q <= PH_LIT_BYTES;
								end
								PH_OFF_GAMMA: begin
									if (gamma_q == GW'(EndMark)) begin
										phase_q <= PH_END;
									end else begin
										ro_q    <= OffW'(gamma_q);
										phase_q <= PH_OFF_BYTE;
									end
								end
								PH_REP_GAMMA: begin
									rem_q   <= RW'(gamma_q);
									phase_q <= bad_off ? PH_ERROR : PH_COPY;
								end
								PH_LEN_GAMMA: begin
									rem_q   <= RW'(gamma_q) + RW'(1);
									phase_q <= bad_off ? PH_ERROR : PH_COPY;
								end
								default: phase_q <= phase_q;
							endcase
						end else if (!half_q) begin
							half_q <= 1'b1;
						end else begin
							half_q  <= 1'b0;
							gamma_q <= capped[GW-1:0];
						end
					end
				end
				S_WR: begin
					res_vld_q  <= 1'b1;
					res_byte_q <= rdata;
					wp_q   <= (wp_q == WpLast) ? '0 : wp_q + AW'(1);
					prod_q <= (prod_q < PCW'(WINDOW_DEPTH)) ? prod_q + PCW'(1) : prod_q;
					rem_q  <= rem_dec;
					if (rem_zero) begin
						phase_q <= PH_SEL_COPY;
					end
				end
				default: begin
					res_vld_q <= res_vld_q;
				end
			endcase
		end
	end

	zx0sd_hist_ram #(
		.DEPTH(WINDOW_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);
endmodule

FILE: hw/rtl/zx0sd_hist_ram.sv
// History window memory with one write port and a registered read port.
module zx0sd_hist_ram #(
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);
	logic [7:0] mem [DEPTH];

	// Write and read in the same clocked block.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/zx0sd_checker.sv
// Port checker for the ZX0 stream decompressor and its bind statement.
`include "assert_macros.svh"
module zx0sd_port_checker
	import zx0sd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_vld,
	input logic       out_ready,
	input logic       out_valid,
	input logic [7:0] out_byte,
	input logic [1:0] status
);
	// The block holds one item at a time.
	`ASSERT_CLK(a_no_overlap, !(out_vld && in_ready), "input ready while a result waits")
	`ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready right after an item")
	// A result without data carries a zero byte.
	`ASSERT_CLK(a_empty_zero, !(out_vld && !out_valid && out_byte != 8'd0), "stray output byte")
	// Errors are sticky until reset.
	`ASSERT_NEXT(a_err_sticky, status == ST_ERROR, status == ST_ERROR, "left error state")
	// A shown result holds until taken.
	`ASSERT_NEXT(a_out_hold, out_vld && !out_ready, out_vld && $stable(out_byte), "result dropped")
endmodule

bind zx0_stream_decompressor zx0sd_port_checker u_zx0sd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_vld  (out_ch.valid),
	.out_ready(out_ch.ready),
	.out_valid(out_ch.out_valid),
	.out_byte (out_ch.out_byte),
	.status   (out_ch.status)
);
